// File: rtl/ucs_pkg.sv
// ----------------------------------------------------------------------------
// ucs_pkg
// Shared types and constants of the URL credential scrubber: hold depth,
// character codes, push selector codes and the controller/datapath bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package ucs_pkg;

  localparam int HOLD_DEPTH = 48;
  localparam int PTR_W      = $clog2(HOLD_DEPTH);
  localparam int CNT_W      = $clog2(HOLD_DEPTH + 1);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_AT    = 8'h40;

  typedef logic [1:0] psel_t;
  localparam psel_t PSEL_IN    = 2'd0;
  localparam psel_t PSEL_STAR  = 2'd1;
  localparam psel_t PSEL_COLON = 2'd2;
  localparam psel_t PSEL_AT    = 2'd3;

  typedef struct packed {
    logic  load;
    logic  set_stop;
    logic  set_scan;
    logic  erase;
    logic  push;
    psel_t psel;
    logic  pop;
    logic  pop_last;
    logic  emit_slash;
    logic  emit_end;
    logic  clear_url;
  } ucs_cmd_t;

  typedef struct packed {
    logic is_stop;
    logic is_at;
    logic is_slash;
    logic last;
    logic stopped;
    logic cnt_zero;
    logic cnt_one;
    logic full;
    logic had_colon;
    logic mask;
    logic out_free;
  } ucs_sts_t;

endpackage

`default_nettype wire

// File: rtl/url_credential_scrubber.sv
// ----------------------------------------------------------------------------
// url_credential_scrubber
// Streams a URL byte by byte and removes or masks user:password before '@'.
// ----------------------------------------------------------------------------
// One URL byte per input transaction; the result stream carries the cleaned
// bytes, with tlast on the final result of each URL (a bare end marker with
// has_byte low when nothing is left). Bytes after the last '/' sit in a
// 48-entry hold memory until a '/', the last byte or an overflow releases
// them. Every hold memory operation is a read state then an act state, set
// by the registered read port: a plain byte is pushed in its act state, a
// flush reads and emits each held byte in turn, a trailing '/' or bare end
// marker needs an empty check, then an emit, and a masked '@' inserts up
// to 10 bytes. Stalls on out_tready hold the emitting states. The user must
// write mask_credentials through cfg_wr_en only while the block is idle;
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module url_credential_scrubber (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_wr_data,  // mask_credentials
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,     // in_byte
  input  wire logic       in_tlast,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,    // out_byte
  output logic            out_tlast,
  output logic [2:0]      out_tuser     // has_byte, null_result, overflow
);
  import ucs_pkg::*;

  ucs_cmd_t cmd;
  ucs_sts_t sts;

  ucs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ucs_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

`default_nettype wire

// File: rtl/ucs_datapath.sv
// ----------------------------------------------------------------------------
// ucs_datapath
// Hold memory with head pointer and count, per-URL flags, mask register and
// the output register; acts on controller commands.
// ----------------------------------------------------------------------------
`default_nettype none

module ucs_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic              cfg_wr_data,
  input  wire logic [7:0]        in_tdata,
  input  wire logic              in_tlast,
  input  wire logic              out_tready,
  output logic                   out_tvalid,
  output logic [7:0]             out_tdata,
  output logic                   out_tlast,
  output logic [2:0]             out_tuser,
  input  wire ucs_pkg::ucs_cmd_t cmd,
  output ucs_pkg::ucs_sts_t      sts
);
  import ucs_pkg::*;

  logic [7:0]       hold_mem [HOLD_DEPTH];
  logic [7:0]       rdata_r;
  logic [PTR_W-1:0] head_r, head_nxt, head_inc, tail;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] colon_r, colon_nxt;
  logic [CNT_W:0]   tail_sum;
  logic [7:0]       byte_r;
  logic             last_r;
  logic             stopped_r, stopped_nxt;
  logic             scan_r, scan_nxt;
  logic             ovf_r, ovf_nxt;
  logic             had_colon_r;
  logic             mask_r;
  logic             full;
  logic [7:0]       push_byte;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic             out_has_r, out_has_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_null_r, out_null_nxt;
  logic             out_ovf_r, out_ovf_nxt;
  logic             out_free;

  assign full     = (count_r == CNT_W'(HOLD_DEPTH));
  assign out_free = !out_valid_r || out_tready;
  assign head_inc = (head_r == PTR_W'(HOLD_DEPTH - 1)) ? '0 : head_r + PTR_W'(1);
  assign tail_sum = {{(CNT_W + 1 - PTR_W){1'b0}}, head_r} + {1'b0, count_r};
  assign tail     = (tail_sum >= (CNT_W + 1)'(HOLD_DEPTH))
                    ? PTR_W'(tail_sum - (CNT_W + 1)'(HOLD_DEPTH))
                    : PTR_W'(tail_sum);

  always_comb begin
    case (cmd.psel)
      PSEL_IN:    push_byte = byte_r;
      PSEL_STAR:  push_byte = CH_STAR;
      PSEL_COLON: push_byte = CH_COLON;
      PSEL_AT:    push_byte = CH_AT;
      default:    push_byte = byte_r;
    endcase
  end

  always_comb begin
    head_nxt      = head_r;
    count_nxt     = count_r;
    colon_nxt     = colon_r;
    stopped_nxt   = stopped_r;
    scan_nxt      = scan_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_byte_nxt  = out_byte_r;
    out_has_nxt   = out_has_r;
    out_last_nxt  = out_last_r;
    out_null_nxt  = out_null_r;
    out_ovf_nxt   = out_ovf_r;
    if (cmd.set_stop) begin
      stopped_nxt = 1'b1;
    end
    if (cmd.set_scan) begin
      scan_nxt = 1'b1;
    end
    if (cmd.erase) begin
      count_nxt = '0;
      colon_nxt = '0;
    end
    if (cmd.push) begin
      if (full) begin
        head_nxt      = head_inc;
        ovf_nxt       = 1'b1;
        out_valid_nxt = 1'b1;
        out_byte_nxt  = rdata_r;
        out_has_nxt   = 1'b1;
        out_last_nxt  = 1'b0;
        out_null_nxt  = 1'b0;
        out_ovf_nxt   = 1'b1;
        colon_nxt     = colon_r - CNT_W'((rdata_r == CH_COLON) && (colon_r != '0))
                        + CNT_W'(push_byte == CH_COLON);
      end else begin
        count_nxt = count_r + CNT_W'(1);
        colon_nxt = colon_r + CNT_W'(push_byte == CH_COLON);
      end
    end
    if (cmd.pop) begin
      head_nxt      = head_inc;
      count_nxt     = count_r - CNT_W'(1);
      if (count_r == CNT_W'(1)) begin
        colon_nxt = '0;
      end
      out_valid_nxt = 1'b1;
      out_byte_nxt  = rdata_r;
      out_has_nxt   = 1'b1;
      out_last_nxt  = cmd.pop_last;
      out_null_nxt  = 1'b0;
      out_ovf_nxt   = ovf_r;
    end
    if (cmd.emit_slash) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = CH_SLASH;
      out_has_nxt   = 1'b1;
      out_last_nxt  = last_r;
      out_null_nxt  = 1'b0;
      out_ovf_nxt   = ovf_r;
    end
    if (cmd.emit_end) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = CH_NUL;
      out_has_nxt   = 1'b0;
      out_last_nxt  = 1'b1;
      out_null_nxt  = !scan_r;
      out_ovf_nxt   = ovf_r;
    end
    if (cmd.clear_url) begin
      count_nxt   = '0;
      colon_nxt   = '0;
      stopped_nxt = 1'b0;
      scan_nxt    = 1'b0;
      ovf_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= hold_mem[head_r];
    if (cmd.push) begin
      hold_mem[tail] <= push_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      colon_r     <= '0;
      stopped_r   <= 1'b0;
      scan_r      <= 1'b0;
      ovf_r       <= 1'b0;
      mask_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      colon_r     <= colon_nxt;
      stopped_r   <= stopped_nxt;
      scan_r      <= scan_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        mask_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_r <= in_tdata;
      last_r <= in_tlast;
    end
    if (cmd.erase) begin
      had_colon_r <= (colon_r != '0);
    end
    out_byte_r <= out_byte_nxt;
    out_has_r  <= out_has_nxt;
    out_last_r <= out_last_nxt;
    out_null_r <= out_null_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign sts.is_stop   = (byte_r == CH_HASH) || (byte_r == CH_QUEST)
                         || (byte_r == CH_SEMI) || (byte_r == CH_NUL);
  assign sts.is_at     = (byte_r == CH_AT);
  assign sts.is_slash  = (byte_r == CH_SLASH);
  assign sts.last      = last_r;
  assign sts.stopped   = stopped_r;
  assign sts.cnt_zero  = (count_r == '0);
  assign sts.cnt_one   = (count_r == CNT_W'(1));
  assign sts.full      = full;
  assign sts.had_colon = had_colon_r;
  assign sts.mask      = mask_r;
  assign sts.out_free  = out_free;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_ovf_r, out_null_r, out_has_r};

endmodule

`default_nettype wire

// File: rtl/ucs_ctrl.sv
// ----------------------------------------------------------------------------
// ucs_ctrl
// Controller: decodes each accepted byte and sequences pushes, mask
// insertion, flushes and end markers over the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module ucs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire ucs_pkg::ucs_sts_t sts,
  output ucs_pkg::ucs_cmd_t      cmd
);
  import ucs_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DECODE   = 3'd1;
  localparam logic [2:0] S_PUSH_RD  = 3'd2;
  localparam logic [2:0] S_PUSH_ACT = 3'd3;
  localparam logic [2:0] S_FLUSH_RD = 3'd4;
  localparam logic [2:0] S_FLUSH_EM = 3'd5;
  localparam logic [2:0] S_SLASH_EM = 3'd6;
  localparam logic [2:0] S_END      = 3'd7;

  localparam logic [3:0] STEP_FIRST      = 4'd0;
  localparam logic [3:0] STEP_STARS_DONE = 4'd3;
  localparam logic [3:0] STEP_COLON      = 4'd4;
  localparam logic [3:0] STEP_AT         = 4'd9;

  logic [2:0] state_r, state_nxt;
  logic [3:0] step_r, step_nxt;
  logic       seq_in_r, seq_in_nxt;
  logic       slash_r, slash_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_nxt  = state_r;
    step_nxt   = step_r;
    seq_in_nxt = seq_in_r;
    slash_nxt  = slash_r;
    if (seq_in_r) begin
      cmd.psel = PSEL_IN;
    end else if (step_r == STEP_COLON) begin
      cmd.psel = PSEL_COLON;
    end else if (step_r == STEP_AT) begin
      cmd.psel = PSEL_AT;
    end else begin
      cmd.psel = PSEL_STAR;
    end
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        slash_nxt = 1'b0;
        if (sts.stopped || sts.is_stop) begin
          cmd.set_stop = 1'b1;
          state_nxt    = sts.last ? S_FLUSH_RD : S_IDLE;
        end else begin
          cmd.set_scan = 1'b1;
          if (sts.is_at) begin
            cmd.erase = 1'b1;
            if (sts.mask) begin
              step_nxt   = STEP_FIRST;
              seq_in_nxt = 1'b0;
              state_nxt  = S_PUSH_RD;
            end else begin
              state_nxt = sts.last ? S_FLUSH_RD : S_IDLE;
            end
          end else if (sts.is_slash) begin
            slash_nxt = 1'b1;
            state_nxt = S_FLUSH_RD;
          end else begin
            seq_in_nxt = 1'b1;
            state_nxt  = S_PUSH_RD;
          end
        end
      end
      S_PUSH_RD: begin
        state_nxt = S_PUSH_ACT;
      end
      S_PUSH_ACT: begin
        if (!sts.full || sts.out_free) begin
          cmd.push = 1'b1;
          if (seq_in_r || (step_r == STEP_AT)) begin
            state_nxt = sts.last ? S_FLUSH_RD : S_IDLE;
          end else begin
            step_nxt  = (step_r == STEP_STARS_DONE && !sts.had_colon)
                        ? STEP_AT : step_r + 4'd1;
            state_nxt = S_PUSH_RD;
          end
        end
      end
      S_FLUSH_RD: begin
        if (sts.cnt_zero) begin
          state_nxt = slash_r ? S_SLASH_EM : S_END;
        end else begin
          state_nxt = S_FLUSH_EM;
        end
      end
      S_FLUSH_EM: begin
        if (sts.out_free) begin
          cmd.pop = 1'b1;
          if (!slash_r && sts.cnt_one) begin
            cmd.pop_last  = 1'b1;
            cmd.clear_url = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            state_nxt = S_FLUSH_RD;
          end
        end
      end
      S_SLASH_EM: begin
        if (sts.out_free) begin
          cmd.emit_slash = 1'b1;
          cmd.clear_url  = sts.last;
          state_nxt      = S_IDLE;
        end
      end
      S_END: begin
        if (sts.out_free) begin
          cmd.emit_end  = 1'b1;
          cmd.clear_url = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      step_r   <= STEP_FIRST;
      seq_in_r <= 1'b0;
      slash_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      step_r   <= step_nxt;
      seq_in_r <= seq_in_nxt;
      slash_r  <= slash_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/ucs_checker.sv
// ----------------------------------------------------------------------------
// ucs_checker
// Port-level checks on the result stream of the URL credential scrubber.
// ----------------------------------------------------------------------------
`default_nettype none

module ucs_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tlast,
  input wire logic [2:0] out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tlast) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tlast && out_tdata == 8'h00)
    else $error("bare marker not final or carries data");

  a_null: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> !out_tuser[0] && !out_tuser[2])
    else $error("null result with data or overflow");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tuser[2] && !out_tlast
      |=> !out_tvalid || out_tuser[2])
    else $error("overflow flag dropped within a URL");

endmodule

bind url_credential_scrubber ucs_checker u_ucs_checker (.*);

`default_nettype wire
